// File: src/wrf_pkg.sv
// Shared types and constants of the windowed rank filter.
`default_nettype none

package wrf_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SAMPLE_W     = 48;
    localparam int WLEN_W       = 5;
    localparam int FRAC_W       = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;

    // rank = (n * fraction + half) >> 8
    localparam int RANK_SHIFT = 8;
    localparam int PROD_W     = CNT_W + FRAC_W;
    localparam int RANK_W     = PROD_W - RANK_SHIFT;
    localparam int RANK_HALF  = 128;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_FRACTION = 1'b1;

    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = WLEN_W'(16);
    localparam logic [FRAC_W-1:0] RANK_FRACTION_RESET = '0;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_REMOVE  = 2'd1,
        CELL_INSERT  = 2'd2,
        CELL_ADVANCE = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t             cmd;
        logic [SAMPLE_W-1:0]   key;
    } cell_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVICT  = 5'b00010,
        ST_INSERT = 5'b00100,
        ST_RANK   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// File: src/wrf_if.sv
// Valid/ready channel interfaces for samples and filtered results.
`default_nettype none

interface wrf_in_if
    import wrf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface wrf_out_if
    import wrf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] filtered_value;

    modport source (output valid, output filtered_value, input ready);
    modport sink   (input valid, input filtered_value, output ready);
endinterface

`default_nettype wire

// File: src/wrf_cell.sv
// One slot of the sorted window: current and previous generation entry.
`default_nettype none

module wrf_cell
    import wrf_pkg::*;
(
    input  wire logic                clk,
    input  wire cell_ctl_t           ctl,
    input  wire logic                valid,
    input  wire logic                left_le,
    input  wire logic [SAMPLE_W-1:0] left_value,
    input  wire logic [SAMPLE_W-1:0] right_value,
    output logic      [SAMPLE_W-1:0] value,
    output logic                     le,
    output logic      [SAMPLE_W-1:0] prev_value
);

    logic [SAMPLE_W-1:0] cur_reg;
    logic [SAMPLE_W-1:0] cur_next;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] prev_next;
    logic                lt;

    // invalid slots compare as larger than any key
    assign lt = valid && (cur_reg < ctl.key);
    assign le = valid && (cur_reg <= ctl.key);

    always_comb
    begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        case (ctl.cmd)
            CELL_REMOVE:
            begin
                if (!lt)
                begin
                    cur_next = right_value;
                end
            end
            CELL_INSERT:
            begin
                if (!le)
                begin
                    cur_next = left_le ? ctl.key : left_value;
                end
            end
            CELL_ADVANCE:
            begin
                prev_next = cur_reg;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
    end

    assign value      = cur_reg;
    assign prev_value = prev_reg;

endmodule

`default_nettype wire

// File: src/windowed_rank_filter_max_bandwidth.sv
// Top level: two-generation sliding-window rank filter over bandwidth samples.
// An accepted transaction passes the sequencer states evict (insert into a full
// window only), insert (inserts only), rank and done; the sequencer steps the
// cell row one command per cycle and takes no new transaction until the result
// is loaded into the output register, which can stall on results.ready.
// Reset (async, active low) empties both generations, clears the ring head and
// loads window_length = 16, rank_fraction_q8 = 0; no clearing pass is needed.
`default_nettype none

module windowed_rank_filter_max_bandwidth
    import wrf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    wrf_in_if.sink                     samples,
    wrf_out_if.source                  results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0] wlen_reg;
    logic [FRAC_W-1:0] frac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WINDOW_LENGTH_RESET;
            frac_reg <= RANK_FRACTION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: wlen_reg <= cfg_data[WLEN_W-1:0];
                CFG_RANK_FRACTION: frac_reg <= cfg_data[FRAC_W-1:0];
                default:           wlen_reg <= wlen_reg;
            endcase
        end
    end

    // Window length clamped to 1..WINDOW_DEPTH
    logic [CNT_W-1:0] eff_len;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (CNT_W'(WINDOW_DEPTH) < WLEN_W'(wlen_reg))
        begin
            eff_len = CNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_len = CNT_W'(wlen_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    prev_count_reg;
    logic [CNT_W-1:0]    prev_count_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] evict_key_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SAMPLE_W-1:0] out_value_reg;
    logic [SAMPLE_W-1:0] cand_cur_reg;
    logic [SAMPLE_W-1:0] cand_prev_reg;

    // Arrival ring, written at the tail, head entry read out on accept
    logic [SAMPLE_W-1:0] ring_reg [WINDOW_DEPTH];
    logic [CNT_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_idx;

    logic       accept;
    logic       out_load;
    cell_ctl_t  ctl;

    assign accept   = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    assign tail_sum = CNT_W'(head_reg) + count_reg;
    assign tail_idx = tail_sum[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        prev_count_next = prev_count_reg;
        ctl.cmd         = CELL_HOLD;
        ctl.key         = sample_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (samples.op == OP_ADVANCE)
                    begin
                        // empty current generation: advance is a no-op
                        if (count_reg != '0)
                        begin
                            ctl.cmd         = CELL_ADVANCE;
                            prev_count_next = count_reg;
                            count_next      = '0;
                            head_next       = '0;
                        end
                        state_next = ST_RANK;
                    end
                    else if (count_reg >= eff_len)
                    begin
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end
            ST_EVICT:
            begin
                // oldest sample leaves the ring and the sorted row
                ctl.cmd    = CELL_REMOVE;
                ctl.key    = evict_key_reg;
                head_next  = head_reg + IDX_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                ctl.cmd    = CELL_INSERT;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            prev_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            prev_count_reg <= prev_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // head does not move between accept and eviction, so the oldest sample
    // is read out of the ring on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg    <= samples.sample;
            evict_key_reg <= ring_reg[head_reg];
        end
        if (state_reg == ST_INSERT)
        begin
            ring_reg[tail_idx] <= sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell row: sorted ascending, slot i valid while i < count
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] cur_vals  [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] prev_vals [WINDOW_DEPTH];
    logic                cell_le   [WINDOW_DEPTH];

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic                cell_valid;
        logic                left_le;
        logic [SAMPLE_W-1:0] left_value;
        logic [SAMPLE_W-1:0] right_value;

        assign cell_valid = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            // new key lands in slot 0 if nothing valid is below it
            assign left_le    = 1'b1;
            assign left_value = ctl.key;
        end
        else
        begin : g_inner
            assign left_le    = cell_le[i-1];
            assign left_value = cur_vals[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            assign right_value = cur_vals[i];
        end
        else
        begin : g_body
            assign right_value = cur_vals[i+1];
        end

        wrf_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (cell_valid),
            .left_le     (left_le),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cur_vals[i]),
            .le          (cell_le[i]),
            .prev_value  (prev_vals[i])
        );
    end

    // ------------------------------------------------------------------
    // Rank selection: rank r counted from the largest, 0 once r reaches n
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] cur_rsum;
    logic [PROD_W-1:0] prev_rsum;
    logic [RANK_W-1:0] cur_rank;
    logic [RANK_W-1:0] prev_rank;
    logic [RANK_W-1:0] cur_pos;
    logic [RANK_W-1:0] prev_pos;
    logic              cur_hit;
    logic              prev_hit;

    assign cur_rsum  = PROD_W'(count_reg) * PROD_W'(frac_reg) + PROD_W'(RANK_HALF);
    assign prev_rsum = PROD_W'(prev_count_reg) * PROD_W'(frac_reg) + PROD_W'(RANK_HALF);
    assign cur_rank  = cur_rsum[PROD_W-1:RANK_SHIFT];
    assign prev_rank = prev_rsum[PROD_W-1:RANK_SHIFT];
    assign cur_hit   = RANK_W'(count_reg) > cur_rank;
    assign prev_hit  = RANK_W'(prev_count_reg) > prev_rank;
    assign cur_pos   = RANK_W'(count_reg) - RANK_W'(1) - cur_rank;
    assign prev_pos  = RANK_W'(prev_count_reg) - RANK_W'(1) - prev_rank;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RANK)
        begin
            cand_cur_reg  <= cur_hit  ? cur_vals[cur_pos[IDX_W-1:0]]   : '0;
            cand_prev_reg <= prev_hit ? prev_vals[prev_pos[IDX_W-1:0]] : '0;
        end
        if (out_load)
        begin
            out_value_reg <= (cand_prev_reg > cand_cur_reg) ? cand_prev_reg : cand_cur_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result until the sink takes it
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.filtered_value = out_value_reg;

endmodule

`default_nettype wire

// File: src/wrf_checker.sv
// Port-level assertions for the rank filter, bound to the top level.
`default_nettype none

module wrf_checker
    import wrf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [SAMPLE_W-1:0] out_value
);

    // a stalled result stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result changed while stalled");

    // one transaction in flight: no new accept straight after one
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted while a transaction is in flight");

    // nothing offered during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind windowed_rank_filter_max_bandwidth wrf_checker u_wrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.filtered_value)
);

`default_nettype wire

// File: bench/windowed_rank_filter_max_bandwidth_tb.sv
// Self-checking bench for the two-generation windowed rank filter: random and directed traffic.
`timescale 1ns / 1ps

module windowed_rank_filter_max_bandwidth_tb;
    import wrf_pkg::*;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_HALF   = 64;     // transactions per half phase
    localparam int HOLD_CYCLES  = 200;    // long receiver back-pressure stretch
    localparam int SETTLE_CYCLES = 8;     // margin past the worst-case latency

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } filter_txn_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wrf_in_if  samples_if ();
    wrf_out_if results_if ();

    windowed_rank_filter_max_bandwidth DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Per-phase register settings. The window list covers 0 (acts as 1), 1, the
    // full depth and values past it; the fraction list covers 0, 1.0 and above.
    // Phase 5 never advances, so the 16-deep window it leaves behind is shrunk
    // to 3 in phase 6 without an advance.
    int phase_wlen    [NUM_PHASES] = '{16, 4, 1, 0, 31, 16, 3, 8, 17, 2, 16, 7};
    int phase_frac    [NUM_PHASES] = '{0, 128, 256, 64, 511, 26, 255, 100, 1, 300, 192, 77};
    int phase_adv_pct [NUM_PHASES] = '{10, 20, 15, 5, 10, 0, 10, 3, 25, 10, 2, 8};

    filter_txn_t         pending_items [$];     // transactions not yet offered
    logic [SAMPLE_W-1:0] expected_filtered [$]; // predicted results in order

    int send_idle_pct;
    int recv_idle_pct;
    int holds_requested;
    int holds_served;
    int hold_left;

    int mismatch_cnt;
    int accepted_cnt;
    int advance_cnt;
    int checked_cnt;

    logic [SAMPLE_W-1:0] dup_pool [4];          // small value set to force duplicates
    filter_txn_t         next_item;

    // ---------------------------------------------------------------------
    // Filter predictor: own copy of the configuration and both generations
    // ---------------------------------------------------------------------
    logic [WLEN_W-1:0]   wlen_r;
    logic [FRAC_W-1:0]   frac_r;
    logic [SAMPLE_W-1:0] ring_q      [WINDOW_DEPTH];  // arrival order
    logic [IDX_W-1:0]    head;                        // slot of the oldest sample
    logic [SAMPLE_W-1:0] cur_sorted  [WINDOW_DEPTH];  // ascending
    int unsigned         cur_n;
    logic [SAMPLE_W-1:0] prev_sorted [WINDOW_DEPTH];  // ascending
    int unsigned         prev_n;

    // Entry of rank round(n * fraction) from the largest; 0 when empty or when
    // the rank runs off the end (r at or above n, as for any fraction of 1.0 or more).
    function automatic logic [SAMPLE_W-1:0] ranked_value(
        input logic [SAMPLE_W-1:0] arr [WINDOW_DEPTH],
        input int unsigned         n
    );
        int unsigned r;
        if (n == 0)
            return '0;
        r = (n * frac_r + RANK_HALF) >> RANK_SHIFT;
        if (r >= n)
            return '0;
        return arr[n - 1 - r];
    endfunction

    function automatic logic [SAMPLE_W-1:0] filter_step(
        input logic                op,
        input logic [SAMPLE_W-1:0] s
    );
        int unsigned         win;
        int unsigned         i;
        int                  pos;
        bit                  found;
        logic [SAMPLE_W-1:0] oldest;
        logic [SAMPLE_W-1:0] prev_val;
        logic [SAMPLE_W-1:0] cur_val;
        logic [IDX_W-1:0]    tail;
        if (op == OP_INSERT)
        begin
            win = (wlen_r == 0) ? 1 : (wlen_r > WINDOW_DEPTH) ? WINDOW_DEPTH : wlen_r;
            // Full (or shrunk) window: drop exactly one copy of the oldest sample.
            if (cur_n >= win)
            begin
                oldest = ring_q[head];
                head   = head + 1'b1;
                found  = 0;
                for (i = 0; i < cur_n; i++)
                begin
                    if (!found && cur_sorted[i] == oldest)
                        found = 1;
                    if (found && i + 1 < cur_n)
                        cur_sorted[i] = cur_sorted[i + 1];
                end
                if (found)
                    cur_n--;
            end
            tail         = head + IDX_W'(cur_n);
            ring_q[tail] = s;
            if (cur_n < WINDOW_DEPTH)
            begin
                pos = cur_n;
                while (pos > 0 && cur_sorted[pos - 1] > s)
                begin
                    cur_sorted[pos] = cur_sorted[pos - 1];
                    pos--;
                end
                cur_sorted[pos] = s;
                cur_n++;
            end
        end
        else if (cur_n != 0)
        begin
            // Advance on an empty current generation leaves everything alone.
            prev_sorted = cur_sorted;
            prev_n      = cur_n;
            cur_n       = 0;
            head        = '0;
        end
        prev_val = ranked_value(prev_sorted, prev_n);
        cur_val  = ranked_value(cur_sorted, cur_n);
        return (prev_val > cur_val) ? prev_val : cur_val;
    endfunction

    // ---------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------
    // Driver: predicts on every accepted transaction, then offers the next
    // pending one unless the random gap says idle this cycle.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid  <= 1'b0;
            samples_if.op     <= OP_INSERT;
            samples_if.sample <= '0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                expected_filtered.push_back(filter_step(samples_if.op, samples_if.sample));
                accepted_cnt++;
                if (samples_if.op == OP_ADVANCE)
                    advance_cnt++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item          = pending_items.pop_front();
                    samples_if.valid  <= 1'b1;
                    samples_if.op     <= next_item.op;
                    samples_if.sample <= next_item.sample;
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Long back-pressure stretch, counted here so the sender keeps offering
    // while the block fills up and stalls its input.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (holds_requested != holds_served)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                checked_cnt++;
                if (expected_filtered.size() == 0)
                begin
                    $display("%0t: filtered_value expected none, actual %h",
                             $time, results_if.filtered_value);
                    mismatch_cnt++;
                end
                else if (results_if.filtered_value !== expected_filtered[0])
                begin
                    $display("%0t: filtered_value expected %h, actual %h",
                             $time, expected_filtered[0], results_if.filtered_value);
                    mismatch_cnt++;
                    void'(expected_filtered.pop_front());
                end
                else
                begin
                    void'(expected_filtered.pop_front());
                end
            end
            results_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // Registers are only touched while idle, so the predictor copy is updated
    // right away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_WINDOW_LENGTH)
            wlen_r = WLEN_W'(val);
        else
            frac_r = FRAC_W'(val);
    endtask

    // Wait until every transaction is offered, taken and answered. Sampled at
    // the falling edge so the driver's updates of the same edge are settled.
    task automatic wait_idle;
        do
            @(negedge clk);
        while (pending_items.size() != 0 || samples_if.valid || expected_filtered.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_item(input logic op, input logic [SAMPLE_W-1:0] s);
        filter_txn_t t;
        t.op     = op;
        t.sample = s;
        pending_items.push_back(t);
    endtask

    // Mix of full-range, extreme, small and repeated samples.
    function automatic logic [SAMPLE_W-1:0] random_sample;
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2, 3:    return dup_pool[$urandom_range(3)];
            4, 5:    return SAMPLE_W'($urandom_range(1000));
            default: return SAMPLE_W'({$urandom, $urandom});
        endcase
    endfunction

    // Queued at the falling edge so the driver never races the pushes.
    task automatic add_random_items(input int n, input int adv_pct);
        @(negedge clk);
        repeat (n)
            queue_item(($urandom_range(99) < adv_pct) ? OP_ADVANCE : OP_INSERT,
                       random_sample());
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_WINDOW_LENGTH;
        cfg_data          = '0;
        samples_if.valid  = 1'b0;
        samples_if.op     = OP_INSERT;
        samples_if.sample = '0;
        results_if.ready  = 1'b0;
        send_idle_pct     = 33;
        recv_idle_pct     = 66;
        holds_requested   = 0;
        mismatch_cnt      = 0;
        accepted_cnt      = 0;
        advance_cnt       = 0;
        checked_cnt       = 0;
        wlen_r            = WINDOW_LENGTH_RESET;
        frac_r            = RANK_FRACTION_RESET;
        head              = '0;
        cur_n             = 0;
        prev_n            = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset settings (window 16, rank 0 = maximum).
        @(negedge clk);
        queue_item(OP_ADVANCE, '1);               // advance with nothing current
        queue_item(OP_INSERT, '0);
        queue_item(OP_INSERT, '1);
        queue_item(OP_INSERT, '1);                // duplicate of the maximum
        queue_item(OP_INSERT, 48'h1);
        queue_item(OP_INSERT, 48'h8000_0000_0000);
        queue_item(OP_INSERT, 48'h7FFF_FFFF_FFFF);
        queue_item(OP_ADVANCE, '0);
        queue_item(OP_ADVANCE, 48'h5555_5555_5555); // current empty again: no change
        queue_item(OP_INSERT, 48'h5);
        queue_item(OP_INSERT, 48'h5);
        queue_item(OP_INSERT, 48'hAAAA_AAAA_AAAA);
        queue_item(OP_ADVANCE, '0);
        queue_item(OP_INSERT, 48'h3);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Sender/receiver gap schedule, then a stretch with no gaps.
            send_idle_pct <= (p < 4) ? 33 : (p < 8) ? 66 : 0;
            recv_idle_pct <= (p < 4) ? 66 : (p < 8) ? 33 : 0;
            write_reg(CFG_WINDOW_LENGTH, phase_wlen[p]);
            write_reg(CFG_RANK_FRACTION, phase_frac[p]);
            foreach (dup_pool[k])
                dup_pool[k] = ($urandom_range(1)) ? SAMPLE_W'({$urandom, $urandom})
                                                  : SAMPLE_W'($urandom_range(20));
            if (p == 8 || p == 10)
            begin
                @(posedge clk);
                holds_requested <= holds_requested + 1;
            end
            // Two halves with a full drain between: the sender stops until
            // every outstanding result is back.
            add_random_items(PHASE_HALF, phase_adv_pct[p]);
            wait_idle();
            add_random_items(PHASE_HALF, phase_adv_pct[p]);
            wait_idle();
        end

        mismatch_cnt += expected_filtered.size();
        $display("Ran %0d transactions (%0d advances) over %0d register settings,",
                 accepted_cnt, advance_cnt, NUM_PHASES + 1);
        $display("checked %0d results, %0d mismatches.", checked_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
